// File: src/tpag_pkg.sv
// Shared types, register indexes and helpers for the tensor permute address generator.
package tpag_pkg;

   localparam int NUM_DIMS     = 4;
   localparam int SIZE_BITS    = 13;
   localparam int PERM_BITS    = 8;
   localparam int CSR_IDX_BITS = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] REG_SIZE_DIM0 = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SIZE_DIM1 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SIZE_DIM2 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SIZE_DIM3 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_PERM_CODE = 3'd4;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 13'd1;
   localparam logic [PERM_BITS-1:0] PERM_RESET = 8'd228;

   typedef logic [NUM_DIMS-1:0][SIZE_BITS-1:0] size_array_type;

   // Control from the top level to the coordinate walker.
   typedef struct packed {
      logic restart;
      logic advance;
   } tpag_ctl_type;

   // Status from the stride setup unit.
   typedef struct packed {
      logic busy;
      logic error;
   } tpag_setup_type;

   // Clamps a configured extent into 1..max_dim.
   function automatic logic [31:0] clamp_extent(input logic [SIZE_BITS-1:0] size,
                                                input logic [31:0] max_dim);
      logic [31:0] wide;
      wide = {{(32-SIZE_BITS){1'b0}}, size};
      if (wide == 32'd0) begin
         return 32'd1;
      end else if (wide > max_dim) begin
         return max_dim;
      end
      return wide;
   endfunction

endpackage

// File: src/tpag_setup.sv
// Stride setup unit: one multiply per cycle over the permuted dimensions.
module tpag_setup #(
   parameter int MAX_DIM   = 4096,
   parameter int ADDR_BITS = 24
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              start,
   input  tpag_pkg::size_array_type                          sizes,
   input  logic [tpag_pkg::PERM_BITS-1:0]                    perm_code,
   output logic [tpag_pkg::NUM_DIMS-1:0][ADDR_BITS-1:0]      stride,
   output tpag_pkg::tpag_setup_type                          status
);
   import tpag_pkg::*;

   localparam int EXT_BITS = $clog2(MAX_DIM + 1);
   localparam int PW       = ADDR_BITS + 1 + EXT_BITS;
   localparam logic [PW-1:0] ADDR_SPAN = PW'(1) << ADDR_BITS;

   logic                                busy_ff, busy_in;
   logic [1:0]                          step_ff, step_in;
   logic [ADDR_BITS:0]                  post_ff, post_in;
   logic                                ovf_ff, ovf_in;
   logic                                err_ff, err_in;
   logic [NUM_DIMS-1:0][ADDR_BITS-1:0]  stride_ff, stride_in;

   logic                perm_ok;
   logic                range_err;
   logic [1:0]          src;
   logic [31:0]         ext_raw;
   logic [EXT_BITS-1:0] ext;
   logic [PW-1:0]       prod;

   always_comb begin
      perm_ok = 1'b1;
      for (int i = 0; i < NUM_DIMS; i++) begin
         for (int j = i + 1; j < NUM_DIMS; j++) begin
            if (perm_code[2*i +: 2] == perm_code[2*j +: 2]) begin
               perm_ok = 1'b0;
            end
         end
      end
      range_err = 1'b0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         if (sizes[d] == '0 ||
             {{(32-SIZE_BITS){1'b0}}, sizes[d]} > 32'(MAX_DIM)) begin
            range_err = 1'b1;
         end
      end
   end

   // Output dimension step_ff names the source dimension handled this cycle.
   assign src     = perm_code[{step_ff, 1'b0} +: 2];
   assign ext_raw = clamp_extent(sizes[src], 32'(MAX_DIM));
   assign ext     = ext_raw[EXT_BITS-1:0];
   assign prod    = PW'(post_ff) * PW'(ext);

   always_comb begin
      busy_in   = busy_ff;
      step_in   = step_ff;
      post_in   = post_ff;
      ovf_in    = ovf_ff;
      err_in    = err_ff;
      stride_in = stride_ff;
      if (start) begin
         busy_in   = 1'b1;
         step_in   = 2'd3;
         post_in   = (ADDR_BITS + 1)'(1);
         ovf_in    = 1'b0;
         stride_in = '0;
      end else if (busy_ff) begin
         if (perm_ok) begin
            stride_in[src] = post_ff[ADDR_BITS-1:0];
         end
         post_in = prod[ADDR_BITS:0];
         // Any partial product beyond the address space means the whole tensor is.
         ovf_in  = ovf_ff | (prod > ADDR_SPAN);
         step_in = step_ff - 2'd1;
         if (step_ff == 2'd0) begin
            busy_in = 1'b0;
            err_in  = range_err | ~perm_ok | ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         step_ff   <= 2'd3;
         post_ff   <= (ADDR_BITS + 1)'(1);
         ovf_ff    <= 1'b0;
         err_ff    <= 1'b0;
         stride_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         step_ff   <= step_in;
         post_ff   <= post_in;
         ovf_ff    <= ovf_in;
         err_ff    <= err_in;
         stride_ff <= stride_in;
      end
   end

   assign stride       = stride_ff;
   assign status.busy  = busy_ff;
   assign status.error = err_ff;

endmodule

// File: src/tpag_walk.sv
// Mixed-radix coordinate counter with running per-dimension address offsets.
module tpag_walk #(
   parameter int MAX_DIM   = 4096,
   parameter int ADDR_BITS = 24
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  tpag_pkg::tpag_ctl_type                        ctl,
   input  tpag_pkg::size_array_type                      sizes,
   input  logic [tpag_pkg::NUM_DIMS-1:0][ADDR_BITS-1:0]  stride,
   input  logic                                          error,
   output logic [ADDR_BITS-1:0]                          address,
   output logic                                          last
);
   import tpag_pkg::*;

   localparam int CRD_BITS = $clog2(MAX_DIM);

   logic [NUM_DIMS-1:0][CRD_BITS-1:0]  coord_ff, coord_in;
   logic [NUM_DIMS-1:0][ADDR_BITS-1:0] offset_ff, offset_in;
   logic [NUM_DIMS-1:0][31:0]          ext_raw;
   logic [NUM_DIMS-1:0][CRD_BITS-1:0]  lim;
   logic [NUM_DIMS-1:0]                at_lim;
   logic [NUM_DIMS:0]                  carry;
   logic [ADDR_BITS-1:0]               sum;

   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         ext_raw[d] = clamp_extent(sizes[d], 32'(MAX_DIM));
         lim[d]     = CRD_BITS'(ext_raw[d] - 32'd1);
         at_lim[d]  = (coord_ff[d] == lim[d]);
      end
      // carry[d] is set when every dimension from d inward sits at its limit.
      carry[NUM_DIMS] = 1'b1;
      for (int d = NUM_DIMS - 1; d >= 0; d--) begin
         carry[d] = carry[d+1] & at_lim[d];
      end
      sum = '0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         sum = sum + offset_ff[d];
      end
   end

   always_comb begin
      coord_in  = coord_ff;
      offset_in = offset_ff;
      if (ctl.restart) begin
         coord_in  = '0;
         offset_in = '0;
      end else if (ctl.advance) begin
         for (int d = 0; d < NUM_DIMS; d++) begin
            if (carry[d+1]) begin
               if (at_lim[d]) begin
                  coord_in[d]  = '0;
                  offset_in[d] = '0;
               end else begin
                  coord_in[d]  = coord_ff[d] + CRD_BITS'(1);
                  offset_in[d] = offset_ff[d] + stride[d];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_ff  <= '0;
         offset_ff <= '0;
      end else begin
         coord_ff  <= coord_in;
         offset_ff <= offset_in;
      end
   end

   assign address = error ? '0 : sum;
   assign last    = carry[0];

endmodule

// File: src/tensor_permute_address_gen.sv
// Top level of the tensor permute address generator: registers, handshakes and result stage.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_element_in
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_dest_address, rsp_element_out,
//           |           |                      | rsp_last_element, rsp_config_error
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One item per cycle while req_stall is low; its result sits in the output register in the
// cycle after it is taken. After reset, and after each write to a known register, the stride
// setup unit does one multiply per dimension with req_stall high; the write also restarts
// the coordinate counter. req_stall is also high while a held result is stalled.
// Reset is synchronous and active high and loads sizes of 1 and the identity order.
module tensor_permute_address_gen #(
   parameter int MAX_DIM   = 4096,
   parameter int ADDR_BITS = 24,
   parameter int DATA_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [DATA_BITS-1:0]                 req_element_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ADDR_BITS-1:0]                 rsp_dest_address,
   output logic [DATA_BITS-1:0]                 rsp_element_out,
   output logic                                 rsp_last_element,
   output logic                                 rsp_config_error,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tpag_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tpag_pkg::SIZE_BITS-1:0]       csr_data
);
   import tpag_pkg::*;

   size_array_type         size_ff, size_in;
   logic [PERM_BITS-1:0]   perm_ff, perm_in;
   logic                   cfg_restart;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0]   addr_ff;
   logic [DATA_BITS-1:0]   data_ff;
   logic                   last_ff;
   logic                   err_ff;

   logic                                setup_start;
   logic [NUM_DIMS-1:0][ADDR_BITS-1:0]  stride;
   tpag_setup_type                      setup_status;
   tpag_ctl_type                        walk_ctl;
   logic [ADDR_BITS-1:0]                walk_addr;
   logic                                walk_last;
   logic                                req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      size_in     = size_ff;
      perm_in     = perm_ff;
      cfg_restart = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SIZE_DIM0: begin
               size_in[0]  = csr_data;
               cfg_restart = 1'b1;
            end
            REG_SIZE_DIM1: begin
               size_in[1]  = csr_data;
               cfg_restart = 1'b1;
            end
            REG_SIZE_DIM2: begin
               size_in[2]  = csr_data;
               cfg_restart = 1'b1;
            end
            REG_SIZE_DIM3: begin
               size_in[3]  = csr_data;
               cfg_restart = 1'b1;
            end
            REG_PERM_CODE: begin
               perm_in     = csr_data[PERM_BITS-1:0];
               cfg_restart = 1'b1;
            end
            default: begin
               cfg_restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= {NUM_DIMS{SIZE_RESET}};
         perm_ff <= PERM_RESET;
      end else begin
         size_ff <= size_in;
         perm_ff <= perm_in;
      end
   end

   assign setup_start = cfg_restart;

   tpag_setup #(
      .MAX_DIM   (MAX_DIM),
      .ADDR_BITS (ADDR_BITS)
   ) u_setup (
      .clock     (clock),
      .reset     (reset),
      .start     (setup_start),
      .sizes     (size_ff),
      .perm_code (perm_ff),
      .stride    (stride),
      .status    (setup_status)
   );

   assign req_stall = setup_status.busy | cfg_restart | (rsp_valid_ff & rsp_stall);
   assign req_take  = req_valid & ~req_stall;

   assign walk_ctl.restart = cfg_restart;
   assign walk_ctl.advance = req_take;

   tpag_walk #(
      .MAX_DIM   (MAX_DIM),
      .ADDR_BITS (ADDR_BITS)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .ctl     (walk_ctl),
      .sizes   (size_ff),
      .stride  (stride),
      .error   (setup_status.error),
      .address (walk_addr),
      .last    (walk_last)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         addr_ff <= walk_addr;
         data_ff <= req_element_in;
         last_ff <= walk_last;
         err_ff  <= setup_status.error;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dest_address = addr_ff;
   assign rsp_element_out  = data_ff;
   assign rsp_last_element = last_ff;
   assign rsp_config_error = err_ff;

endmodule

// File: src/tpag_checker.sv
// Port-level assertions for the tensor permute address generator, bound to the top level.
module tpag_checker #(
   parameter int ADDR_BITS = 24,
   parameter int DATA_BITS = 32
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [DATA_BITS-1:0]               req_element_in,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [ADDR_BITS-1:0]               rsp_dest_address,
   input logic [DATA_BITS-1:0]               rsp_element_out,
   input logic                               rsp_last_element,
   input logic                               rsp_config_error
);

   // The result register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A taken item always shows up as a result in the next cycle.
   a_item_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid && rsp_element_out == $past(req_element_in))
      else $error("accepted item did not reach the result register");

   // An error verdict always comes with a zero address.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_config_error |-> rsp_dest_address == '0)
      else $error("error result with nonzero address");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_dest_address) && $stable(rsp_last_element) &&
                                 $stable(rsp_element_out) && $stable(rsp_config_error))
      else $error("stalled result changed");

endmodule

bind tensor_permute_address_gen tpag_checker #(
   .ADDR_BITS (ADDR_BITS),
   .DATA_BITS (DATA_BITS)
) u_tpag_checker (.*);
